// File: hdl/lcdr_pkg.sv
package lcdr_pkg;

    localparam int STORE_ROWS = 128;
    localparam int ROW_LANES  = 8;
    localparam int ROW_BYTES  = 16;
    localparam int RESULTS    = ROW_BYTES + 2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [7:0] CMD_BASE  = 8'h80;
    localparam logic [7:0] CMD_HALF  = 8'h08;
    localparam logic [6:0] FULL_STOP = 7'd64;
    localparam logic [2:0] LAST_BAND = 3'd4;

    typedef struct packed {
        logic [5:0] y;
        logic       done;
        logic [2:0] next_band;
    } t_row_info;

    function automatic logic [6:0] f_band_start(input logic [2:0] band);
        logic [6:0] row;
        case (band)
            3'd0:    row = 7'd0;
            3'd1:    row = 7'd13;
            3'd2:    row = 7'd26;
            3'd3:    row = 7'd39;
            3'd4:    row = 7'd52;
            default: row = 7'd0;
        endcase
        return row;
    endfunction

    function automatic logic [6:0] f_band_stop(input logic [2:0] band);
        logic [6:0] row;
        case (band)
            3'd0:    row = 7'd13;
            3'd1:    row = 7'd26;
            3'd2:    row = 7'd39;
            3'd3:    row = 7'd52;
            3'd4:    row = 7'd64;
            default: row = 7'd13;
        endcase
        return row;
    endfunction

endpackage

// File: hdl/page_to_row_lcd_refresh.sv
// channel  | handshake          | payload
// request  | start / busy       | i_operation, i_address, i_data, i_full_req
// result   | o_strobe           | o_is_data, o_value, o_last, o_band_done, o_next_band
//
// A write goes into the store as it is accepted; busy stays low.
// During a refresh busy is high until the final beat and drops on that beat,
// so the next request can be accepted while the final beat is in progress.
// 18 bytes come out one per cycle, the first strobed once r_busy and then r_strobe
// are set after acceptance; the frame store gives one 8-byte row per read.
// Reset is synchronous; valid bits make unwritten store rows read as zero.
// Results cannot be stalled.
module page_to_row_lcd_refresh (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_operation,
    input  logic [9:0] i_address,
    input  logic [7:0] i_data,
    input  logic       i_full_req,
    output logic       o_strobe,
    output logic       o_is_data,
    output logic [7:0] o_value,
    output logic       o_last,
    output logic       o_band_done,
    output logic [2:0] o_next_band
);
    import lcdr_pkg::*;

    localparam logic [4:0] LAST_BEAT = 5'(RESULTS - 1);

    logic       accept;
    logic       refresh_go;
    logic       write_go;
    logic       rd_en;
    logic [6:0] rd_row;
    logic [63:0] rd_word;
    logic [7:0] gathered;
    logic [3:0] beat_m1;
    t_row_info  row_now;

    logic       r_busy;
    logic [4:0] r_beat;
    t_row_info  r_row;
    logic       r_strobe;
    logic       r_is_data;
    logic [7:0] r_value;
    logic       r_last;
    logic       r_band_done;
    logic [2:0] r_next_band;

    assign busy       = r_busy && (r_beat != LAST_BEAT);
    assign accept     = start && !busy;
    assign refresh_go = accept && (i_operation == OP_REFRESH);
    assign write_go   = accept && (i_operation == OP_WRITE);

    assign beat_m1 = r_beat[3:0] - 4'd1;
    assign rd_en   = r_busy && (r_beat >= 5'd1) && (r_beat <= 5'(ROW_BYTES));
    assign rd_row  = {r_row.y[5:3], beat_m1};

    lcdr_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (write_go),
        .i_wr_addr (i_address),
        .i_wr_data (i_data),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .o_rd_word (rd_word)
    );

    lcdr_band u_band (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (refresh_go),
        .i_full    (i_full_req),
        .o_row     (row_now)
    );

    always_comb begin
        for (int k = 0; k < ROW_LANES; k++) begin
            gathered[ROW_LANES-1-k] = rd_word[k*8 + int'(r_row.y[2:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (refresh_go) begin
            r_row <= row_now;
        end
        r_band_done <= r_row.done;
        r_next_band <= r_row.next_band;
        r_last      <= (r_beat == LAST_BEAT);
        case (r_beat)
            5'd0: begin
                r_is_data <= 1'b0;
                r_value   <= CMD_BASE | {3'd0, r_row.y[4:0]};
            end
            5'd1: begin
                r_is_data <= 1'b0;
                r_value   <= CMD_BASE | (r_row.y[5] ? CMD_HALF : 8'd0);
            end
            default: begin
                r_is_data <= 1'b1;
                r_value   <= gathered;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_beat   <= 5'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy;
            if (refresh_go) begin
                r_busy <= 1'b1;
                r_beat <= 5'd0;
            end else if (r_busy) begin
                if (r_beat == LAST_BEAT) begin
                    r_busy <= 1'b0;
                    r_beat <= 5'd0;
                end else begin
                    r_beat <= r_beat + 5'd1;
                end
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_is_data   = r_is_data;
    assign o_value     = r_value;
    assign o_last      = r_last;
    assign o_band_done = r_band_done;
    assign o_next_band = r_next_band;

endmodule

// File: hdl/lcdr_store.sv
module lcdr_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [9:0]  i_wr_addr,
    input  logic [7:0]  i_wr_data,
    input  logic        i_rd_en,
    input  logic [6:0]  i_rd_row,
    output logic [63:0] o_rd_word
);
    import lcdr_pkg::*;

    logic [63:0]           r_mem [0:STORE_ROWS-1];
    logic [STORE_ROWS-1:0] r_valid;
    logic [63:0]           r_rd_word;
    logic                  r_rd_valid;
    logic [6:0]            wr_row;
    logic [2:0]            wr_lane;

    assign wr_row  = i_wr_addr[9:3];
    assign wr_lane = i_wr_addr[2:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (r_valid[wr_row]) begin
                r_mem[wr_row][wr_lane*8 +: 8] <= i_wr_data;
            end else begin
                r_mem[wr_row] <= {56'd0, i_wr_data} << {wr_lane, 3'd0};
            end
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_row];
            end
        end
    end

    assign o_rd_word = r_rd_valid ? r_rd_word : 64'd0;

endmodule

// File: hdl/lcdr_band.sv
module lcdr_band (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_full,
    output lcdr_pkg::t_row_info o_row
);
    import lcdr_pkg::*;

    logic [6:0] r_cursor, n_cursor;
    logic [6:0] r_stop, n_stop;
    logic [2:0] r_index, n_index;
    logic       r_active, n_active;
    logic [6:0] cur;
    logic [6:0] stop_row;
    logic [6:0] nxt;
    logic [2:0] band;
    logic [2:0] idx;
    logic       done;

    always_comb begin
        cur      = r_cursor;
        stop_row = r_stop;
        idx      = r_index;
        band     = (r_index <= LAST_BAND) ? r_index : 3'd0;
        if (!r_active) begin
            if (i_full) begin
                cur      = 7'd0;
                stop_row = FULL_STOP;
                idx      = 3'd0;
            end else begin
                cur      = f_band_start(band);
                stop_row = f_band_stop(band);
                idx      = (band == LAST_BAND) ? 3'd0 : band + 3'd1;
            end
        end
        nxt  = cur + 7'd1;
        done = (nxt >= stop_row) || (nxt >= FULL_STOP);

        o_row.y         = cur[5:0];
        o_row.done      = done;
        o_row.next_band = idx;

        n_cursor = r_cursor;
        n_stop   = r_stop;
        n_index  = r_index;
        n_active = r_active;
        if (i_advance) begin
            n_cursor = nxt;
            n_stop   = stop_row;
            n_index  = idx;
            n_active = !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= 7'd0;
            r_stop   <= 7'd0;
            r_index  <= 3'd0;
            r_active <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_stop   <= n_stop;
            r_index  <= n_index;
            r_active <= n_active;
        end
    end

endmodule

// File: hdl/lcdr_checker.sv
module lcdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_operation,
    input logic       o_strobe,
    input logic       o_is_data,
    input logic [7:0] o_value,
    input logic       o_last
);
    import lcdr_pkg::*;

    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == OP_REFRESH) |=> busy)
        else $error("refresh request did not raise busy");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> o_is_data)
        else $error("last byte of row is not a data byte");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe || !o_is_data)
        else $error("data byte follows the last byte of a row");

    a_hcmd_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_data && $past(o_strobe && !o_is_data)
            |-> (o_value == 8'h80) || (o_value == 8'h88))
        else $error("horizontal address command has a bad value");

endmodule

bind page_to_row_lcd_refresh lcdr_checker u_lcdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_strobe    (o_strobe),
    .o_is_data   (o_is_data),
    .o_value     (o_value),
    .o_last      (o_last)
);
